FILE: hdl/quaternion_vector_rotate_macros.svh
// assertion helpers used by the top rtl file
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// same-cycle implication
`define QVR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;
   localparam int QUAT_WIDTH = 16;
   localparam int VEC_WIDTH  = 32;
   localparam int COEF_FRAC  = 30;
   // square / cross product of two quaternion parts
   localparam int PROD_W     = 2 * QUAT_WIDTH;
   // squared norm, unsigned
   localparam int NORM_W     = PROD_W + 1;
   // matrix entry, signed, |m| <= norm
   localparam int MAT_W      = PROD_W + 2;
   localparam int QUO_W      = COEF_FRAC + 1;
   localparam int DIVD_W     = NORM_W + COEF_FRAC;
   localparam int REM_W      = NORM_W + 1;
   localparam int COEF_W     = QUO_W + 1;
   localparam int MUL_W      = COEF_W + VEC_WIDTH;
   localparam int ACC_W      = MUL_W + 2;
   localparam int DIV_STAGES = QUO_W;
   localparam int LANES      = 9;
endpackage

FILE: hdl/qvr_div_lane.sv
`timescale 1ns / 1ps
// pipelined m * 2^frac / n, ties away from zero, one quotient bit per stage
module qvr_div_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [qvr_pkg::MAT_W-1:0]   mat_i,
   input  logic        [qvr_pkg::NORM_W-1:0]  norm_i,
   output logic signed [qvr_pkg::COEF_W-1:0]  coef_o
);
   import qvr_pkg::*;

   logic                neg_ff [0:DIV_STAGES];
   logic [NORM_W-1:0]   den_ff [0:DIV_STAGES];
   logic [REM_W-1:0]    rem_ff [0:DIV_STAGES];
   logic [QUO_W-1:0]    quo_ff [0:DIV_STAGES];
   logic [QUO_W-1:0]    low_ff [0:DIV_STAGES];

   logic                neg_in;
   logic [MAT_W-1:0]    mag_full;
   logic [DIVD_W-1:0]   divd_in;

   always_comb begin
      neg_in   = mat_i[MAT_W-1];
      mag_full = neg_in ? MAT_W'(-mat_i) : MAT_W'(mat_i);
      divd_in  = {mag_full[NORM_W-1:0], {COEF_FRAC{1'b0}}}
               + DIVD_W'(norm_i >> 1);
   end

   // prep stage
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= neg_in;
         den_ff[0] <= norm_i;
         rem_ff[0] <= REM_W'(divd_in[DIVD_W-1:QUO_W]);
         low_ff[0] <= divd_in[QUO_W-1:0];
         quo_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      logic [REM_W-1:0] trial;
      logic             fits;
      always_comb begin
         trial = {rem_ff[s-1][REM_W-2:0], low_ff[s-1][QUO_W-1]};
         fits  = trial >= REM_W'(den_ff[s-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s] <= neg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            rem_ff[s] <= fits ? trial - REM_W'(den_ff[s-1]) : trial;
            quo_ff[s] <= {quo_ff[s-1][QUO_W-2:0], fits};
            low_ff[s] <= {low_ff[s-1][QUO_W-2:0], 1'b0};
         end
      end
   end

   assign coef_o = neg_ff[DIV_STAGES] ? -$signed({1'b0, quo_ff[DIV_STAGES]})
                                      : $signed({1'b0, quo_ff[DIV_STAGES]});
endmodule

FILE: hdl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// quaternion vector rotation
// req channel: one item carries a quaternion (Q1.14) and a vector (Q15.16);
// it is taken when req_valid and req_ready are high at a clock edge
// rsp channel: one item per request, the vector rotated by the inverse of
// the quaternion and divided by its squared norm, with a zero-norm flag
// and a clip flag; taken when rsp_valid and rsp_ready are high
// each matrix entry goes through a 31 stage restoring divider
// that turns it into a Q1.30 coefficient
// throughput is one item per cycle while the receiver keeps rsp_ready high
// when the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated, and it resumes as soon
// as the result is taken
// reset (synchronous, active high) clears every valid bit; the block keeps
// no other state, so no clearing pass is needed
// a zero quaternion gives zero outputs with zero_norm_error set
module quaternion_vector_rotate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_w,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_z,
   input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  req_vec_x,
   input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  req_vec_y,
   input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  req_vec_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rsp_out_x,
   output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rsp_out_y,
   output logic signed [qvr_pkg::VEC_WIDTH-1:0]  rsp_out_z,
   output logic                                 rsp_zero_norm_error,
   output logic                                 rsp_saturated
);
   import qvr_pkg::*;
   `include "quaternion_vector_rotate_macros.svh"

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'(1) << (VEC_WIDTH-1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

   // whole pipeline moves together unless a result is stuck at the output
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage a: products of quaternion parts
   logic                        va_ff;
   logic signed [PROD_W-1:0]    ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0]    xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [VEC_WIDTH-1:0] veca_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ww_ff <= PROD_W'(req_quat_w * req_quat_w);
         xx_ff <= PROD_W'(req_quat_x * req_quat_x);
         yy_ff <= PROD_W'(req_quat_y * req_quat_y);
         zz_ff <= PROD_W'(req_quat_z * req_quat_z);
         xy_ff <= PROD_W'(req_quat_x * req_quat_y);
         wz_ff <= PROD_W'(req_quat_w * req_quat_z);
         xz_ff <= PROD_W'(req_quat_x * req_quat_z);
         wy_ff <= PROD_W'(req_quat_w * req_quat_y);
         yz_ff <= PROD_W'(req_quat_y * req_quat_z);
         wx_ff <= PROD_W'(req_quat_w * req_quat_x);
         veca_ff[0] <= req_vec_x;
         veca_ff[1] <= req_vec_y;
         veca_ff[2] <= req_vec_z;
      end
   end

   // ---------------- stage b: matrix entries and squared norm
   logic signed [MAT_W-1:0] mat_in [0:LANES-1];
   logic [NORM_W-1:0]       norm_in;

   always_comb begin
      norm_in   = NORM_W'(MAT_W'(ww_ff) + MAT_W'(xx_ff) + MAT_W'(yy_ff) + MAT_W'(zz_ff));
      mat_in[0] = MAT_W'(ww_ff) + MAT_W'(xx_ff) - MAT_W'(yy_ff) - MAT_W'(zz_ff);
      mat_in[1] = (MAT_W'(xy_ff) + MAT_W'(wz_ff)) <<< 1;
      mat_in[2] = (MAT_W'(xz_ff) - MAT_W'(wy_ff)) <<< 1;
      mat_in[3] = (MAT_W'(xy_ff) - MAT_W'(wz_ff)) <<< 1;
      mat_in[4] = MAT_W'(ww_ff) - MAT_W'(xx_ff) + MAT_W'(yy_ff) - MAT_W'(zz_ff);
      mat_in[5] = (MAT_W'(yz_ff) + MAT_W'(wx_ff)) <<< 1;
      mat_in[6] = (MAT_W'(xz_ff) + MAT_W'(wy_ff)) <<< 1;
      mat_in[7] = (MAT_W'(yz_ff) - MAT_W'(wx_ff)) <<< 1;
      mat_in[8] = MAT_W'(ww_ff) - MAT_W'(xx_ff) - MAT_W'(yy_ff) + MAT_W'(zz_ff);
   end

   logic                        vb_ff;
   logic signed [MAT_W-1:0]     mat_ff [0:LANES-1];
   logic [NORM_W-1:0]           norm_ff;
   logic signed [VEC_WIDTH-1:0] vecb_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         norm_ff <= norm_in;
         for (int k = 0; k < LANES; k++) begin
            mat_ff[k] <= mat_in[k];
         end
         for (int j = 0; j < 3; j++) begin
            vecb_ff[j] <= veca_ff[j];
         end
      end
   end

   // ---------------- divider lanes, one per matrix entry
   logic signed [COEF_W-1:0] coef [0:LANES-1];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      qvr_div_lane u_div (
         .clock  (clock),
         .en     (adv),
         .mat_i  (mat_ff[k]),
         .norm_i (norm_ff),
         .coef_o (coef[k])
      );
   end

   // side data follows the divider depth
   logic                        vd_ff   [0:DIV_STAGES];
   logic                        zerod_ff[0:DIV_STAGES];
   logic signed [VEC_WIDTH-1:0] vecd_ff [0:DIV_STAGES][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            vd_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vd_ff[0] <= vb_ff;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            vd_ff[s] <= vd_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zerod_ff[0] <= norm_ff == '0;
         for (int j = 0; j < 3; j++) begin
            vecd_ff[0][j] <= vecb_ff[j];
         end
         for (int s = 1; s <= DIV_STAGES; s++) begin
            zerod_ff[s] <= zerod_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               vecd_ff[s][j] <= vecd_ff[s-1][j];
            end
         end
      end
   end

   // ---------------- stage m: coefficient times vector
   logic                    vm_ff, zerom_ff;
   logic signed [MUL_W-1:0] prod_ff [0:LANES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= vd_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zerom_ff <= zerod_ff[DIV_STAGES];
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[3*i+j] <= MUL_W'(coef[3*i+j]) * MUL_W'(vecd_ff[DIV_STAGES][j]);
            end
         end
      end
   end

   // ---------------- stage c: row sums plus rounding offset
   logic                    vc_ff, zeroc_ff;
   logic signed [ACC_W-1:0] acc_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zeroc_ff <= zerom_ff;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= ACC_W'(prod_ff[3*i]) + ACC_W'(prod_ff[3*i+1])
                       + ACC_W'(prod_ff[3*i+2]) + ROUND_HALF;
         end
      end
   end

   // ---------------- output stage: floor shift, saturate, zero-norm override
   logic signed [ACC_W-1:0]     shr   [0:2];
   logic signed [VEC_WIDTH-1:0] res_in[0:2];
   logic [2:0]                  clip;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shr[i] = acc_ff[i] >>> COEF_FRAC;
         if (shr[i] > OUT_MAX) begin
            res_in[i] = VEC_WIDTH'(OUT_MAX);
            clip[i]   = 1'b1;
         end else if (shr[i] < OUT_MIN) begin
            res_in[i] = VEC_WIDTH'(OUT_MIN);
            clip[i]   = 1'b1;
         end else begin
            res_in[i] = VEC_WIDTH'(shr[i]);
            clip[i]   = 1'b0;
         end
      end
   end

   logic                        rsp_valid_ff;
   logic signed [VEC_WIDTH-1:0] out_ff [0:2];
   logic                        zero_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= zeroc_ff;
         sat_ff  <= !zeroc_ff && (clip != '0);
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= zeroc_ff ? '0 : res_in[i];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = out_ff[0];
   assign rsp_out_y           = out_ff[1];
   assign rsp_out_z           = out_ff[2];
   assign rsp_zero_norm_error = zero_ff;
   assign rsp_saturated       = sat_ff;

   // checks
   `QVR_ASSERT_NOW(a_zero_out, clock, reset, rsp_valid && rsp_zero_norm_error, rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && !rsp_saturated, "zero norm result not cleared")
   `QVR_ASSERT_NOW(a_sat_bound, clock, reset, rsp_valid && rsp_saturated, rsp_out_x == VEC_WIDTH'(OUT_MAX) || rsp_out_x == VEC_WIDTH'(OUT_MIN) || rsp_out_y == VEC_WIDTH'(OUT_MAX) || rsp_out_y == VEC_WIDTH'(OUT_MIN) || rsp_out_z == VEC_WIDTH'(OUT_MAX) || rsp_out_z == VEC_WIDTH'(OUT_MIN), "clip flag without a bound value")
   `QVR_ASSERT_NEXT(a_valid_src, clock, reset, adv && !vc_ff, !rsp_valid, "result without an item behind it")
   `QVR_ASSERT_NEXT(a_hold_pipe, clock, reset, !adv, $stable(vc_ff) && $stable(vm_ff) && $stable(va_ff), "pipeline moved during a stall")
endmodule

FILE: dv/tb_quaternion_vector_rotate.sv
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate;
   import qvr_pkg::*;

   // one predicted result item
   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] x;
      logic signed [VEC_WIDTH-1:0] y;
      logic signed [VEC_WIDTH-1:0] z;
      logic                        zero_norm;
      logic                        sat;
   } rotation_type;

   localparam int LATENCY = 37;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [QUAT_WIDTH-1:0] req_quat_w = '0, req_quat_x = '0;
   logic signed [QUAT_WIDTH-1:0] req_quat_y = '0, req_quat_z = '0;
   logic signed [VEC_WIDTH-1:0]  req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VEC_WIDTH-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_zero_norm_error, rsp_saturated;

   rotation_type pending_rotations[$];
   int errors = 0;
   int sent = 0;
   int got = 0;
   int clipped = 0;
   int zero_norms = 0;
   // idle and stall probability, percent
   int send_idle = 0;
   int stall_pct = 0;

   quaternion_vector_rotate uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ratio m * 2^30 / n, ties away from zero
   function automatic longint rotation_coef(longint m, longint n);
      longint mag;
      longint q;
      mag = (m < 0) ? -m : m;
      q = ((mag <<< COEF_FRAC) + (n >>> 1)) / n;
      return (m < 0) ? -q : q;
   endfunction

   // round the accumulated dot product back to Q15.16 and clip
   function automatic logic signed [VEC_WIDTH-1:0] round_clip(longint acc, ref logic sat);
      longint r;
      longint hi;
      hi = (longint'(1) <<< (VEC_WIDTH - 1)) - 1;
      // arithmetic shift on a signed longint is a floor shift
      r = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (r > hi) begin
         r = hi;
         sat = 1'b1;
      end
      if (r < -hi - 1) begin
         r = -hi - 1;
         sat = 1'b1;
      end
      return r[VEC_WIDTH-1:0];
   endfunction

   // expected rotation of v by the inverse of q
   function automatic rotation_type rotate_inverse(longint w, longint x, longint y, longint z,
                                                   longint vx, longint vy, longint vz);
      rotation_type r;
      longint n;
      longint m[9];
      longint c[9];
      logic sat;
      r = '0;
      sat = 1'b0;
      n = w * w + x * x + y * y + z * z;
      if (n == 0) begin
         r.zero_norm = 1'b1;
         return r;
      end
      m[0] = w * w + x * x - y * y - z * z;
      m[1] = 2 * (x * y + w * z);
      m[2] = 2 * (x * z - w * y);
      m[3] = 2 * (x * y - w * z);
      m[4] = w * w - x * x + y * y - z * z;
      m[5] = 2 * (y * z + w * x);
      m[6] = 2 * (x * z + w * y);
      m[7] = 2 * (y * z - w * x);
      m[8] = w * w - x * x - y * y + z * z;
      for (int i = 0; i < 9; i++) c[i] = rotation_coef(m[i], n);
      r.x = round_clip(c[0] * vx + c[1] * vy + c[2] * vz, sat);
      r.y = round_clip(c[3] * vx + c[4] * vy + c[5] * vz, sat);
      r.z = round_clip(c[6] * vx + c[7] * vy + c[8] * vz, sat);
      r.sat = sat;
      return r;
   endfunction

   // send one item, with a random gap before it
   task automatic send_item(logic [QUAT_WIDTH-1:0] w, x, y, z,
                            logic [VEC_WIDTH-1:0] vx, vy, vz);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // item accepted on this edge
      pending_rotations.push_back(rotate_inverse(
         $signed(w), $signed(x), $signed(y), $signed(z),
         $signed(vx), $signed(vy), $signed(vz)));
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rotations.size() != 0) @(posedge clock);
   endtask

   // receiver ready with random stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker, sampled at the edge
   always @(posedge clock) begin
      rotation_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         got++;
         if (pending_rotations.size() == 0) begin
            $error("result item with no expectation");
            errors++;
         end else begin
            e = pending_rotations.pop_front();
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %0d actual %0d", e.z, rsp_out_z);
               errors++;
            end
            if (rsp_zero_norm_error !== e.zero_norm) begin
               $error("zero_norm_error expected %0b actual %0b", e.zero_norm,
                      rsp_zero_norm_error);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %0b actual %0b", e.sat, rsp_saturated);
               errors++;
            end
            if (e.sat) clipped++;
            if (e.zero_norm) zero_norms++;
         end
      end
   end

   // identity, axis turns and the extremes of every field
   task automatic test_directed();
      send_item(16'sd16384, 0, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536);
      send_item(16'sd11585, 16'sd11585, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536);
      send_item(16'sd11585, 0, 16'sd11585, 0, 32'sd65536, 32'sd65536, 32'sd65536);
      send_item(16'sd11585, 0, 0, 16'sd11585, 32'sd65536, -32'sd65536, 32'sd3);
      send_item(0, 16'sd16384, 0, 0, 32'sd1, 32'sd1, 32'sd1);
      // zero quaternion, with nonzero and zero vectors
      send_item(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h12345678);
      send_item(0, 0, 0, 0, 0, 0, 0);
      // extremes of the quaternion and vector fields
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_item(16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                32'h80000000, 32'h80000000, 32'h80000000);
      send_item(16'h0001, 16'h7fff, 16'h7fff, 16'h0000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(16'h8000, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0);
      send_item(16'h0001, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h80000000);
      send_item(16'h7fff, 16'h0001, 16'hffff, 16'h8000, 32'h1, 32'hffffffff, 32'h0);
   endtask

   // random items, mostly plain rotations with some wide and tiny ones
   task automatic test_random(int count);
      logic [QUAT_WIDTH-1:0] q[4];
      logic [VEC_WIDTH-1:0] v[3];
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(9);
         for (int i = 0; i < 4; i++) begin
            q[i] = QUAT_WIDTH'($urandom);
            if (mode < 5) q[i] = $signed(q[i]) >>> 1;
            else if (mode == 5) q[i] = $signed(q[i]) >>> 12;
            else if (mode == 6 && $urandom_range(1)) q[i] = 0;
         end
         if (mode == 7 && $urandom_range(3) == 0) q = '{0, 0, 0, 0};
         for (int i = 0; i < 3; i++) begin
            v[i] = VEC_WIDTH'($urandom);
            if (mode < 3) v[i] = $signed(v[i]) >>> $urandom_range(20);
         end
         send_item(q[0], q[1], q[2], q[3], v[0], v[1], v[2]);
      end
   endtask

   // sender holds off until the pipeline is empty, then bursts
   task automatic test_drain_pause();
      test_random(20);
      wait_drained();
      test_random(30);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // no idling
      send_idle = 0; stall_pct = 0;
      test_random(160);
      test_drain_pause();
      // sender idle
      send_idle = 48; stall_pct = 0;
      test_random(160);
      // receiver stalls
      send_idle = 0; stall_pct = 48;
      test_random(160);
      // both
      send_idle = 32; stall_pct = 32;
      test_random(160);
      stall_pct = 0;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d items, checked %0d results", sent, got);
      $display("%0d clipped results, %0d zero-norm quaternions", clipped, zero_norms);
      if (errors == 0 && pending_rotations.size() == 0 && !rsp_valid)
         $display("tb_quaternion_vector_rotate OK");
      else
         $display("tb_quaternion_vector_rotate NOT OK");
      $finish;
   end

   // timeout well beyond the slowest correct run
   initial begin
      #2000000;
      $display("tb_quaternion_vector_rotate NOT OK");
      $finish;
   end
endmodule
